FILE: rtl/core/acdu_pkg.sv
// ----------------------------------------------------------------------------
// acdu_pkg
// Shared types, codes, S-box tables and inverse-cipher helpers.
// ----------------------------------------------------------------------------
package acdu_pkg;

    typedef logic [127:0] block_t;

    // job kinds passed from the front end to the decrypt back end
    localparam logic [1:0] KIND_BLOCK = 2'd0;  // full block, 16 bytes out
    localparam logic [1:0] KIND_FINAL = 2'd1;  // last block, trailer removed
    localparam logic [1:0] KIND_BARE  = 2'd2;  // bare end marker only

    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_END  = 1'b1;

    localparam logic [1:0] KEY_SIZE_128 = 2'd0;
    localparam logic [1:0] KEY_SIZE_192 = 2'd1;
    localparam logic [1:0] KEY_SIZE_256 = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        block_t     cipher;
        block_t     iv;
    } job_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Nk: key length in 32-bit words
    function automatic logic [3:0] num_words(input logic [1:0] ksz);
        logic [3:0] nk;
        case (ksz)
            KEY_SIZE_128: nk = 4'd4;
            KEY_SIZE_192: nk = 4'd6;
            default:      nk = 4'd8;
        endcase
        return nk;
    endfunction

    function automatic logic [3:0] num_rounds(input logic [1:0] ksz);
        return num_words(ksz) + 4'd6;
    endfunction

    // byte k of a block sits at bits 127-8k .. 120-8k
    function automatic block_t inv_shift_sub(input block_t s);
        block_t t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8*(r + 4*c) -: 8] = INV_SBOX[s[127 - 8*(r + 4*((c + 4 - r) & 3)) -: 8]];
            end
        end
        return t;
    endfunction

    function automatic block_t inv_mix(input block_t s);
        block_t     t;
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m9 [4];
        logic [7:0] m11 [4];
        logic [7:0] m13 [4];
        logic [7:0] m14 [4];
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                a[r]   = s[127 - 8*(r + 4*c) -: 8];
                x2[r]  = xt(a[r]);
                x4[r]  = xt(x2[r]);
                x8[r]  = xt(x4[r]);
                m9[r]  = x8[r] ^ a[r];
                m11[r] = x8[r] ^ x2[r] ^ a[r];
                m13[r] = x8[r] ^ x4[r] ^ a[r];
                m14[r] = x8[r] ^ x4[r] ^ x2[r];
            end
            t[127 - 8*(4*c)     -: 8] = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
            t[127 - 8*(4*c + 1) -: 8] = m9[0]  ^ m14[1] ^ m11[2] ^ m13[3];
            t[127 - 8*(4*c + 2) -: 8] = m13[0] ^ m9[1]  ^ m14[2] ^ m11[3];
            t[127 - 8*(4*c + 3) -: 8] = m11[0] ^ m13[1] ^ m9[2]  ^ m14[3];
        end
        return t;
    endfunction

endpackage

FILE: rtl/core/aes_cbc_decrypt_unpad_stream.sv
// ----------------------------------------------------------------------------
// aes_cbc_decrypt_unpad_stream
// AES-CBC decrypting byte stream with trailer removal.
// ----------------------------------------------------------------------------
// Use: ciphertext bytes enter on the input channel (command 0) one transfer
// per cycle while in_stall is low; command 1 ends the stream. The first 16
// bytes are the IV; each later full block is held until the next one
// arrives, then decrypted and sent out as 16 plaintext transfers. At end
// of stream the held block is sent minus min(last byte,16) bytes; the final
// transfer carries last. When nothing is left to carry last, a bare marker
// (byte_valid 0) is sent. Throughput: one byte per cycle sustained while
// the output is not stalled. Each block is decrypted in the single shared
// round unit. A released block passes through the queue, the round unit
// and the output register before its first plaintext byte is sent. Reset,
// and every register write, restarts the key schedule; decryption waits
// for it, bytes are still taken. A stalled output holds its byte; the input
// keeps flowing until the job queue fills, then in_stall rises.
// Registers (64-bit APB, 8-byte stride): key_word_0..3, key_size.
// ----------------------------------------------------------------------------
module aes_cbc_decrypt_unpad_stream #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    // ciphertext input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [7:0]  data_byte,
    // plaintext output
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  plain_byte,
    output logic        byte_valid,
    output logic        last,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam logic [2:0] REG_KEY_WORD_0 = 3'd0;
    localparam logic [2:0] REG_KEY_WORD_1 = 3'd1;
    localparam logic [2:0] REG_KEY_WORD_2 = 3'd2;
    localparam logic [2:0] REG_KEY_WORD_3 = 3'd3;
    localparam logic [2:0] REG_KEY_SIZE   = 3'd4;

    logic [63:0]      key_word_reg [4];
    logic [1:0]       key_size_reg;

    logic             cfg_wr;
    logic [2:0]       reg_idx;

    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_empty;
    acdu_pkg::job_t   push_job;
    acdu_pkg::job_t   pop_job;

    logic             key_ready;
    logic [3:0]       rk_idx;
    acdu_pkg::block_t rk;

    // --- register port ---
    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int k = 0; k < 4; k++)
                key_word_reg[k] <= '0;
            key_size_reg <= acdu_pkg::KEY_SIZE_128;
        end
        else if (cfg_wr) begin
            case (reg_idx)
                REG_KEY_WORD_0: key_word_reg[0] <= pwdata;
                REG_KEY_WORD_1: key_word_reg[1] <= pwdata;
                REG_KEY_WORD_2: key_word_reg[2] <= pwdata;
                REG_KEY_WORD_3: key_word_reg[3] <= pwdata;
                // size code three behaves as 256-bit
                REG_KEY_SIZE:   key_size_reg <= (pwdata[1:0] == 2'd3) ? acdu_pkg::KEY_SIZE_256
                                                                      : pwdata[1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_KEY_WORD_0: prdata = key_word_reg[0];
            REG_KEY_WORD_1: prdata = key_word_reg[1];
            REG_KEY_WORD_2: prdata = key_word_reg[2];
            REG_KEY_WORD_3: prdata = key_word_reg[3];
            REG_KEY_SIZE:   prdata = {62'd0, key_size_reg};
            default:        prdata = '0;
        endcase
    end

    // --- key schedule, rerun after any register write ---
    acdu_keyexp u_keyexp (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cfg_wr),
        .key      ({key_word_reg[0], key_word_reg[1], key_word_reg[2], key_word_reg[3]}),
        .key_size (key_size_reg),
        .rd_idx   (rk_idx),
        .rd_key   (rk),
        .ready    (key_ready)
    );

    // --- front: gathers bytes, issues decrypt jobs ---
    acdu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .data_byte (data_byte),
        .q_full    (q_full),
        .push      (q_push),
        .job       (push_job)
    );

    // --- decouples the byte front end from the round unit ---
    acdu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    // --- back: rounds, CBC xor, trailer trim, output register ---
    acdu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_job      (pop_job),
        .pop        (q_pop),
        .key_ready  (key_ready),
        .key_size   (key_size_reg),
        .rk_idx     (rk_idx),
        .rk         (rk),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .plain_byte (plain_byte),
        .byte_valid (byte_valid),
        .last       (last)
    );

`ifndef SYNTH
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("job pushed into full queue");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("job popped from empty queue");

    a_pop_keys_ready: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> key_ready)
        else $error("decrypt started during key schedule");

    a_bare_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !byte_valid) |-> last)
        else $error("bare marker without last");
`endif

endmodule

FILE: rtl/core/acdu_keyexp.sv
// ----------------------------------------------------------------------------
// acdu_keyexp
// Key schedule: one 32-bit word per cycle into a 15-entry round key file.
// ----------------------------------------------------------------------------
module acdu_keyexp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [255:0]          key,
    input  logic [1:0]            key_size,
    input  logic [3:0]            rd_idx,
    output acdu_pkg::block_t      rd_key,
    output logic                  ready
);

    logic             busy_reg;
    logic [5:0]       idx_reg;
    logic [2:0]       mod_reg;
    logic [7:0]       rcon_reg;
    logic [31:0]      win_reg [8];
    acdu_pkg::block_t rk_reg [15];

    logic [31:0] key_words [8];
    logic [3:0]  nk;
    logic [2:0]  nk_m1;
    logic [5:0]  total_m1;
    logic [31:0] t;
    logic [31:0] w_next;
    logic        use_rcon;

    for (genvar g = 0; g < 8; g++) begin : g_kw
        assign key_words[g] = key[255 - 32*g -: 32];
    end

    assign nk       = acdu_pkg::num_words(key_size);
    assign nk_m1    = 3'(nk - 4'd1);
    assign total_m1 = 6'({acdu_pkg::num_rounds(key_size), 2'b00} + 6'd3);

    always_comb
    begin
        t        = win_reg[0];
        use_rcon = 1'b0;
        if (mod_reg == 3'd0) begin
            // RotWord, SubWord, Rcon
            t = {acdu_pkg::SBOX[win_reg[0][23:16]] ^ rcon_reg,
                 acdu_pkg::SBOX[win_reg[0][15:8]],
                 acdu_pkg::SBOX[win_reg[0][7:0]],
                 acdu_pkg::SBOX[win_reg[0][31:24]]};
            use_rcon = 1'b1;
        end
        else if (nk == 4'd8 && mod_reg == 3'd4) begin
            t = {acdu_pkg::SBOX[win_reg[0][31:24]], acdu_pkg::SBOX[win_reg[0][23:16]],
                 acdu_pkg::SBOX[win_reg[0][15:8]], acdu_pkg::SBOX[win_reg[0][7:0]]};
        end
        if ({2'b00, idx_reg} < {4'd0, nk})
            w_next = key_words[idx_reg[2:0]];
        else
            w_next = win_reg[nk_m1] ^ t;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            mod_reg  <= '0;
            rcon_reg <= 8'h01;
        end
        else if (start) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            mod_reg  <= '0;
            rcon_reg <= 8'h01;
        end
        else if (busy_reg) begin
            idx_reg <= idx_reg + 6'd1;
            mod_reg <= (mod_reg == nk_m1) ? 3'd0 : mod_reg + 3'd1;
            if (use_rcon && {2'b00, idx_reg} >= {4'd0, nk})
                rcon_reg <= acdu_pkg::xt(rcon_reg);
            if (idx_reg == total_m1)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !start) begin
            win_reg[0] <= w_next;
            for (int k = 1; k < 8; k++)
                win_reg[k] <= win_reg[k-1];
            rk_reg[idx_reg[5:2]][127 - 32*idx_reg[1:0] -: 32] <= w_next;
        end
    end

    assign rd_key = rk_reg[rd_idx];
    assign ready  = !busy_reg;

endmodule

FILE: rtl/core/acdu_front.sv
// ----------------------------------------------------------------------------
// acdu_front
// Byte gatherer: IV capture, block hold-back, job generation.
// ----------------------------------------------------------------------------
module acdu_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               command,
    input  logic [7:0]         data_byte,
    input  logic               q_full,
    output logic               push,
    output acdu_pkg::job_t     job
);

    localparam logic [1:0] PH_IV     = 2'd0;
    localparam logic [1:0] PH_FIRST  = 2'd1;
    localparam logic [1:0] PH_STREAM = 2'd2;

    logic [1:0]       phase_reg;
    logic [3:0]       count_reg;
    acdu_pkg::block_t gather_reg;
    acdu_pkg::block_t chain_reg;
    acdu_pkg::block_t held_reg;

    logic             accept;
    acdu_pkg::block_t blk;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign blk      = {gather_reg[127:8], data_byte};

    always_comb
    begin
        push        = 1'b0;
        job.kind    = acdu_pkg::KIND_BLOCK;
        job.cipher  = held_reg;
        job.iv      = chain_reg;
        if (accept) begin
            if (command == acdu_pkg::CMD_END) begin
                push     = 1'b1;
                job.kind = (phase_reg == PH_STREAM) ? acdu_pkg::KIND_FINAL
                                                    : acdu_pkg::KIND_BARE;
            end
            else if (count_reg == 4'd15 && phase_reg == PH_STREAM) begin
                push = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_IV;
            count_reg <= '0;
        end
        else if (accept) begin
            if (command == acdu_pkg::CMD_END) begin
                phase_reg <= PH_IV;
                count_reg <= '0;
            end
            else begin
                count_reg <= count_reg + 4'd1;
                if (count_reg == 4'd15) begin
                    case (phase_reg)
                        PH_IV:     phase_reg <= PH_FIRST;
                        PH_FIRST:  phase_reg <= PH_STREAM;
                        PH_STREAM: phase_reg <= PH_STREAM;
                        default:   phase_reg <= PH_FIRST;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && command == acdu_pkg::CMD_DATA) begin
            gather_reg[127 - 8*count_reg -: 8] <= data_byte;
            if (count_reg == 4'd15) begin
                case (phase_reg)
                    PH_FIRST:
                    begin
                        held_reg <= blk;
                    end
                    PH_STREAM:
                    begin
                        chain_reg <= held_reg;
                        held_reg  <= blk;
                    end
                    default:
                    begin
                        chain_reg <= blk;
                    end
                endcase
            end
        end
    end

endmodule

FILE: rtl/core/acdu_queue.sv
// ----------------------------------------------------------------------------
// acdu_queue
// Small job FIFO between the front end and the decrypt back end.
// ----------------------------------------------------------------------------
module acdu_queue #(
    parameter int DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  acdu_pkg::job_t     push_job,
    output logic               full,
    input  logic               pop,
    output acdu_pkg::job_t     pop_job,
    output logic               empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    acdu_pkg::job_t mem_reg [DEPTH];
    logic [PW-1:0]  wr_reg;
    logic [PW-1:0]  rd_reg;
    logic [CW-1:0]  cnt_reg;

    assign full    = (cnt_reg == FULL_CNT);
    assign empty   = (cnt_reg == '0);
    assign pop_job = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else begin
            if (push)
                wr_reg <= (wr_reg == LAST_PTR) ? '0 : wr_reg + PW'(1);
            if (pop)
                rd_reg <= (rd_reg == LAST_PTR) ? '0 : rd_reg + PW'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + CW'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_job;
    end

endmodule

FILE: rtl/core/acdu_back.sv
// ----------------------------------------------------------------------------
// acdu_back
// Iterative inverse-cipher round unit, CBC xor, trailer trim, byte output.
// ----------------------------------------------------------------------------
module acdu_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  acdu_pkg::job_t     q_job,
    output logic               pop,
    input  logic               key_ready,
    input  logic [1:0]         key_size,
    output logic [3:0]         rk_idx,
    input  acdu_pkg::block_t   rk,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         plain_byte,
    output logic               byte_valid,
    output logic               last
);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_RUN  = 2'd1;
    localparam logic [1:0] D_DONE = 2'd2;

    logic [1:0]       dstate_reg;
    logic [3:0]       rnd_reg;
    logic [1:0]       kind_reg;
    acdu_pkg::block_t st_reg;
    acdu_pkg::block_t iv_reg;

    logic             ov_reg;
    acdu_pkg::block_t odata_reg;
    logic [4:0]       orem_reg;
    logic [1:0]       okind_reg;

    logic [3:0]       nr;
    acdu_pkg::block_t isb;
    logic             out_xfer;
    logic             obuf_free;
    logic             load;
    logic [7:0]       pad_byte;
    logic [4:0]       keep;

    assign nr        = acdu_pkg::num_rounds(key_size);
    assign out_xfer  = ov_reg && !out_stall;
    assign obuf_free = !ov_reg || (out_xfer && orem_reg == 5'd1);
    assign load      = (dstate_reg == D_DONE) && obuf_free;
    assign pop       = (dstate_reg == D_IDLE || load) && !q_empty && key_ready;
    assign rk_idx    = (dstate_reg == D_RUN) ? rnd_reg : nr;
    assign isb       = acdu_pkg::inv_shift_sub(st_reg) ^ rk;

    // trailer length is the last plaintext byte, capped at a whole block
    assign pad_byte  = st_reg[7:0];
    assign keep      = (pad_byte > 8'd16) ? 5'd0 : 5'd16 - pad_byte[4:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            dstate_reg <= D_IDLE;
        end
        else if (pop) begin
            dstate_reg <= (q_job.kind == acdu_pkg::KIND_BARE) ? D_DONE : D_RUN;
        end
        else if (load) begin
            dstate_reg <= D_IDLE;
        end
        else if (dstate_reg == D_RUN && rnd_reg == 4'd0) begin
            dstate_reg <= D_DONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            kind_reg <= q_job.kind;
            iv_reg   <= q_job.iv;
            st_reg   <= q_job.cipher ^ rk;
            rnd_reg  <= nr - 4'd1;
        end
        else if (dstate_reg == D_RUN) begin
            if (rnd_reg == 4'd0) begin
                st_reg <= isb ^ iv_reg;
            end
            else begin
                st_reg  <= acdu_pkg::inv_mix(isb);
                rnd_reg <= rnd_reg - 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ov_reg    <= 1'b0;
            orem_reg  <= '0;
            okind_reg <= acdu_pkg::KIND_BARE;
        end
        else if (load) begin
            ov_reg <= 1'b1;
            case (kind_reg)
                acdu_pkg::KIND_BLOCK:
                begin
                    orem_reg  <= 5'd16;
                    okind_reg <= acdu_pkg::KIND_BLOCK;
                end
                acdu_pkg::KIND_FINAL:
                begin
                    orem_reg  <= (keep == 5'd0) ? 5'd1 : keep;
                    okind_reg <= (keep == 5'd0) ? acdu_pkg::KIND_BARE : acdu_pkg::KIND_FINAL;
                end
                default:
                begin
                    orem_reg  <= 5'd1;
                    okind_reg <= acdu_pkg::KIND_BARE;
                end
            endcase
        end
        else if (out_xfer) begin
            orem_reg <= orem_reg - 5'd1;
            if (orem_reg == 5'd1)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            odata_reg <= st_reg;
        else if (out_xfer)
            odata_reg <= {odata_reg[119:0], 8'h00};
    end

    assign out_valid  = ov_reg;
    assign byte_valid = (okind_reg != acdu_pkg::KIND_BARE);
    assign plain_byte = byte_valid ? odata_reg[127:120] : 8'h00;
    assign last       = (okind_reg != acdu_pkg::KIND_BLOCK) && (orem_reg == 5'd1);

endmodule
